@@ sv/cch_pkg.sv @@
// ----------------------------------------------------------------------------
// cch_pkg
// Shared types, constants and the arctangent table for the compass
// calibration and heading block.
// ----------------------------------------------------------------------------
package cch_pkg;

	// request kinds
	typedef enum logic [1:0] {
		ACT_START   = 2'd0,
		ACT_SAMPLE  = 2'd1,
		ACT_TICK    = 2'd2,
		ACT_HEADING = 2'd3
	} action_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_CAL_DONE  = 3'd1,
		ST_HEADING   = 3'd2,
		ST_NOT_CAL   = 3'd3,
		ST_ZERO_SPAN = 3'd4
	} status_t;

	localparam int CORDIC_STEPS_DEF = 20;

	localparam int SMP_W    = 16;
	localparam int DIFF_W   = SMP_W + 1;
	localparam int PROD_W   = 33;
	localparam int SCALE_SH = 24;
	localparam int CORD_W   = 60;
	localparam int Z_W      = 32;
	localparam int ATAN_W   = 30;
	localparam int ATAN_N   = 32;
	localparam int IDX_W    = 5;

	localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
	localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;
	localparam logic [SMP_W-1:0] TIMEOUT_RST = 16'd1000;
	localparam logic [SMP_W-1:0] QUIET_TOP   = 16'hFFFF;

	// quarter turn in centidegrees scaled by 2^16
	localparam logic signed [Z_W-1:0] QUARTER_TURN = 32'sd589824000;
	localparam logic signed [Z_W-1:0] ROUND_HALF   = 32'sd32768;
	localparam logic signed [SMP_W-1:0] HEADING_MAX = 16'sd18000;
	localparam logic signed [SMP_W-1:0] HEADING_MIN = -16'sd18000;

	// atan(2^-i) in centidegrees scaled by 2^16
	function automatic logic [ATAN_W-1:0] cch_atan(input logic [IDX_W-1:0] idx);
		logic [ATAN_W-1:0] v;
		case (idx)
			5'd0:    v = 30'd294912000;
			5'd1:    v = 30'd174096719;
			5'd2:    v = 30'd91987925;
			5'd3:    v = 30'd46694507;
			5'd4:    v = 30'd23437865;
			5'd5:    v = 30'd11730358;
			5'd6:    v = 30'd5866610;
			5'd7:    v = 30'd2933484;
			5'd8:    v = 30'd1466764;
			5'd9:    v = 30'd733385;
			5'd10:   v = 30'd366693;
			5'd11:   v = 30'd183346;
			5'd12:   v = 30'd91673;
			5'd13:   v = 30'd45837;
			5'd14:   v = 30'd22918;
			5'd15:   v = 30'd11459;
			5'd16:   v = 30'd5730;
			5'd17:   v = 30'd2865;
			5'd18:   v = 30'd1432;
			5'd19:   v = 30'd716;
			5'd20:   v = 30'd358;
			5'd21:   v = 30'd179;
			5'd22:   v = 30'd90;
			5'd23:   v = 30'd45;
			5'd24:   v = 30'd22;
			5'd25:   v = 30'd11;
			5'd26:   v = 30'd6;
			5'd27:   v = 30'd3;
			5'd28:   v = 30'd1;
			5'd29:   v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

@@ sv/cch_intf.sv @@
// ----------------------------------------------------------------------------
// cch channel interfaces
// Valid/ready channels for requests, results and the timeout register write.
// ----------------------------------------------------------------------------

// request channel
interface cch_in_if;
	import cch_pkg::*;
	logic                    valid;
	logic                    ready;
	action_t                 action;
	logic signed [SMP_W-1:0] x_sample;
	logic signed [SMP_W-1:0] y_sample;
	logic signed [SMP_W-1:0] z_sample;

	modport source (output valid, action, x_sample, y_sample, z_sample, input ready);
	modport sink (input valid, action, x_sample, y_sample, z_sample, output ready);
endinterface

// result channel
interface cch_out_if;
	import cch_pkg::*;
	logic                    valid;
	logic                    ready;
	status_t                 status;
	logic signed [SMP_W-1:0] heading_centideg;
	logic signed [SMP_W-1:0] offset_x;
	logic signed [SMP_W-1:0] offset_y;
	logic signed [SMP_W-1:0] offset_z;
	logic                    is_calibrated;

	modport source (output valid, status, heading_centideg, offset_x, offset_y, offset_z,
		is_calibrated, input ready);
	modport sink (input valid, status, heading_centideg, offset_x, offset_y, offset_z,
		is_calibrated, output ready);
endinterface

// register write channel
interface cch_cfg_if;
	import cch_pkg::*;
	logic             valid;
	logic             ready;
	logic [SMP_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ sv/compass_calibration_heading.sv @@
// ----------------------------------------------------------------------------
// compass_calibration_heading
// Hard-iron calibration of a three-axis magnetometer and CORDIC compass
// heading in centidegrees.
// ----------------------------------------------------------------------------
// Start, calibration sample and tick requests update the calibration state in
// the cycle they are accepted and pass through the finish state to the output
// register. A heading request runs through one shared 17x17 multiplier twice,
// a pre-rotation step and CORDIC_STEPS iterations of one shared shift/add unit
// plus a rounding step; a zero vector skips the iterations with heading 0.
// The block takes one request at a time. A finished result sits in the output
// register until taken while the next request is already accepted. The timeout
// register write is always ready and should be done while the block is idle.
module compass_calibration_heading import cch_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	cch_in_if.sink    req,
	cch_out_if.source rsp,
	cch_cfg_if.sink   cfg
);

	localparam int STEP_W = $clog2(CORDIC_STEPS + 1);
	localparam int EXT_W  = CORD_W - PROD_W - SCALE_SH;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MULX,
		S_MULY,
		S_ROT,
		S_ITER,
		S_FIN
	} state_t;

	state_t                  state_q;
	logic [SMP_W-1:0]        timeout_q;
	logic signed [SMP_W-1:0] min_q [3];
	logic signed [SMP_W-1:0] max_q [3];
	logic signed [SMP_W-1:0] off_q [3];
	logic [SMP_W-1:0]        span_q [2];
	logic [SMP_W-1:0]        quiet_q;
	logic                    calibrating_q;
	logic                    calibrated_q;

	logic signed [DIFF_W-1:0] dx_q;
	logic signed [DIFF_W-1:0] ndy_q;
	logic signed [PROD_W-1:0] xa_q;
	logic signed [PROD_W-1:0] yb_q;
	logic signed [CORD_W-1:0] x_q;
	logic signed [CORD_W-1:0] y_q;
	logic signed [Z_W-1:0]    z_q;
	logic [STEP_W-1:0]        step_q;
	status_t                  res_status_q;
	logic signed [SMP_W-1:0]  res_heading_q;

	logic                    rsp_valid_q;
	status_t                 rsp_status_q;
	logic signed [SMP_W-1:0] rsp_heading_q;
	logic signed [SMP_W-1:0] rsp_off_q [3];
	logic                    rsp_cal_q;

	logic req_fire;
	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid & req.ready;
	assign cfg.ready = 1'b1;

	// next calibration state for the request at the input
	logic signed [SMP_W-1:0] smp [3];
	logic signed [SMP_W-1:0] mid_w [3];
	logic [SMP_W-1:0]        span_w [2];
	logic signed [SMP_W-1:0] min_n [3];
	logic signed [SMP_W-1:0] max_n [3];
	logic signed [SMP_W-1:0] off_n [3];
	logic [SMP_W-1:0]        span_n [2];
	logic [SMP_W-1:0]        quiet_n;
	logic [SMP_W-1:0]        quiet_inc;
	logic                    calibrating_n;
	logic                    calibrated_n;
	status_t                 status_n;
	logic                    go_heading;

	assign smp[0] = req.x_sample;
	assign smp[1] = req.y_sample;
	assign smp[2] = req.z_sample;
	assign quiet_inc = (quiet_q == QUIET_TOP) ? quiet_q : quiet_q + 16'd1;

	// truncated midpoints and spans of the current extremes
	always_comb begin
		logic signed [DIFF_W-1:0] sum;
		logic signed [DIFF_W-1:0] adj;
		logic signed [DIFF_W-1:0] diff;
		for (int k = 0; k < 3; k++) begin
			sum      = DIFF_W'(min_q[k]) + DIFF_W'(max_q[k]);
			adj      = sum + DIFF_W'({1'b0, sum[DIFF_W-1]});
			mid_w[k] = adj[DIFF_W-1:1];
		end
		for (int k = 0; k < 2; k++) begin
			diff      = DIFF_W'(max_q[k]) - DIFF_W'(min_q[k]);
			span_w[k] = (max_q[k] >= min_q[k]) ? diff[SMP_W-1:0] : '0;
		end
	end

	// request decode and calibration update
	always_comb begin
		logic changed;
		changed       = 1'b0;
		min_n         = min_q;
		max_n         = max_q;
		off_n         = off_q;
		span_n        = span_q;
		quiet_n       = quiet_q;
		calibrating_n = calibrating_q;
		calibrated_n  = calibrated_q;
		status_n      = ST_ACCEPTED;
		go_heading    = 1'b0;
		case (req.action)
			ACT_START: begin
				for (int k = 0; k < 3; k++) begin
					min_n[k] = SMP_MAX;
					max_n[k] = SMP_MIN;
				end
				quiet_n       = '0;
				calibrating_n = 1'b1;
			end
			ACT_SAMPLE: begin
				if (calibrating_q) begin
					for (int k = 0; k < 3; k++) begin
						if (smp[k] < min_q[k]) begin
							min_n[k] = smp[k];
							changed  = 1'b1;
						end
						if (smp[k] > max_q[k]) begin
							max_n[k] = smp[k];
							changed  = 1'b1;
						end
					end
					if (changed) quiet_n = '0;
				end
			end
			ACT_TICK: begin
				if (calibrating_q) begin
					quiet_n = quiet_inc;
					if (quiet_inc >= timeout_q) begin
						off_n         = mid_w;
						span_n        = span_w;
						calibrating_n = 1'b0;
						calibrated_n  = 1'b1;
						status_n      = ST_CAL_DONE;
					end
				end
			end
			ACT_HEADING: begin
				if (!calibrated_q) begin
					status_n = ST_NOT_CAL;
				end else if (span_q[0] == '0 || span_q[1] == '0) begin
					status_n = ST_ZERO_SPAN;
				end else begin
					status_n   = ST_HEADING;
					go_heading = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// shared multiplier, offset-corrected axis times the other axis span
	logic signed [DIFF_W-1:0]   mul_a;
	logic signed [DIFF_W-1:0]   mul_b;
	logic signed [2*DIFF_W-1:0] prod;
	assign mul_a = (state_q == S_MULX) ? dx_q : ndy_q;
	assign mul_b = (state_q == S_MULX) ? $signed({1'b0, span_q[1]})
		: $signed({1'b0, span_q[0]});
	assign prod  = mul_a * mul_b;

	// products widened and scaled for the pre-rotation into the right half plane
	logic signed [CORD_W-1:0] xs;
	logic signed [CORD_W-1:0] ys;
	assign xs = {{EXT_W{xa_q[PROD_W-1]}}, xa_q, {SCALE_SH{1'b0}}};
	assign ys = {{EXT_W{yb_q[PROD_W-1]}}, yb_q, {SCALE_SH{1'b0}}};

	// shared cordic shift/add unit
	logic [IDX_W-1:0]         idx;
	logic signed [CORD_W-1:0] xsh;
	logic signed [CORD_W-1:0] ysh;
	logic signed [Z_W-1:0]    atan_z;
	assign idx    = IDX_W'(step_q);
	assign xsh    = x_q >>> idx;
	assign ysh    = y_q >>> idx;
	assign atan_z = $signed({{(Z_W-ATAN_W){1'b0}}, cch_atan(idx)});

	// rounding of the final angle to centidegrees
	logic signed [Z_W-1:0]   z_rnd;
	logic signed [SMP_W-1:0] ang;
	logic signed [SMP_W-1:0] ang_clamp;
	assign z_rnd = z_q + ROUND_HALF;
	assign ang   = z_rnd[Z_W-1:Z_W-SMP_W];
	assign ang_clamp = (ang > HEADING_MAX) ? HEADING_MAX
		: (ang < HEADING_MIN) ? HEADING_MIN : ang;

	logic rsp_load;
	assign rsp_load = (state_q == S_FIN) && (!rsp_valid_q || rsp.ready);

	// sequencer, calibration state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			timeout_q     <= TIMEOUT_RST;
			quiet_q       <= '0;
			calibrating_q <= 1'b0;
			calibrated_q  <= 1'b0;
			rsp_valid_q   <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				min_q[k] <= SMP_MAX;
				max_q[k] <= SMP_MIN;
				off_q[k] <= '0;
			end
			span_q[0] <= '0;
			span_q[1] <= '0;
		end else begin
			if (cfg.valid) timeout_q <= cfg.data;

			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						min_q         <= min_n;
						max_q         <= max_n;
						off_q         <= off_n;
						span_q        <= span_n;
						quiet_q       <= quiet_n;
						calibrating_q <= calibrating_n;
						calibrated_q  <= calibrated_n;
						res_status_q  <= status_n;
						res_heading_q <= '0;
						dx_q  <= DIFF_W'(req.x_sample) - DIFF_W'(off_q[0]);
						ndy_q <= DIFF_W'(off_q[1]) - DIFF_W'(req.y_sample);
						state_q <= go_heading ? S_MULX : S_FIN;
					end
				end
				S_MULX: begin
					xa_q    <= prod[PROD_W-1:0];
					state_q <= S_MULY;
				end
				S_MULY: begin
					yb_q    <= prod[PROD_W-1:0];
					state_q <= S_ROT;
				end
				S_ROT: begin
					step_q <= '0;
					if (xa_q == '0 && yb_q == '0) begin
						state_q <= S_FIN;
					end else begin
						if (!xa_q[PROD_W-1]) begin
							x_q <= xs;
							y_q <= ys;
							z_q <= '0;
						end else if (!yb_q[PROD_W-1]) begin
							x_q <= ys;
							y_q <= -xs;
							z_q <= QUARTER_TURN;
						end else begin
							x_q <= -ys;
							y_q <= xs;
							z_q <= -QUARTER_TURN;
						end
						state_q <= S_ITER;
					end
				end
				S_ITER: begin
					if (step_q == STEP_W'(CORDIC_STEPS)) begin
						res_heading_q <= ang_clamp;
						state_q       <= S_FIN;
					end else begin
						if (!y_q[CORD_W-1]) begin
							x_q <= x_q + ysh;
							y_q <= y_q - xsh;
							z_q <= z_q + atan_z;
						end else begin
							x_q <= x_q - ysh;
							y_q <= y_q + xsh;
							z_q <= z_q - atan_z;
						end
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_FIN: begin
					if (rsp_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase

			// output register
			if (rsp_load) begin
				rsp_valid_q   <= 1'b1;
				rsp_status_q  <= res_status_q;
				rsp_heading_q <= res_heading_q;
				rsp_off_q     <= off_q;
				rsp_cal_q     <= calibrated_q;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.status           = rsp_status_q;
	assign rsp.heading_centideg = rsp_heading_q;
	assign rsp.offset_x         = rsp_off_q[0];
	assign rsp.offset_y         = rsp_off_q[1];
	assign rsp.offset_z         = rsp_off_q[2];
	assign rsp.is_calibrated    = rsp_cal_q;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for compass_calibration_heading. A short table of
// directed requests covers the corner cases of calibration and heading, then
// well-formed calibration runs with random sample clouds, mixed with noise,
// follow under several quiet timeouts. Every result is checked against a
// prediction of the calibration state and of the CORDIC heading, with random
// gaps on both the request and the result channel.
// ----------------------------------------------------------------------------
module tb import cch_pkg::*; ;

	localparam int CORDIC_ITERS      = 20;
	localparam int RANDOM_REQS       = 900;
	localparam int PHASES            = 5;
	localparam int NUM_ROWS          = 25;
	localparam int SHORT_TIMEOUT_ROW = 8;

	typedef struct {
		status_t            status;
		logic signed [15:0] heading;
		logic signed [15:0] off_x;
		logic signed [15:0] off_y;
		logic signed [15:0] off_z;
		logic               cal;
	} compass_result_t;

	typedef struct {
		action_t            act;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		int                 reps;
		bit                 typed;
		compass_result_t    res;
	} stim_row_t;

	// atan(2^-i) in centidegrees scaled by 2^16
	localparam longint ATAN_CDEG [32] = '{
		294912000, 174096719, 91987925, 46694507, 23437865, 11730358, 5866610, 2933484,
		1466764, 733385, 366693, 183346, 91673, 45837, 22918, 11459,
		5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1, 0, 0};

	logic clk = 1'b0;
	logic arst_n;

	cch_in_if  req_if();
	cch_out_if rsp_if();
	cch_cfg_if cfg_if();

	compass_calibration_heading #(.CORDIC_STEPS(CORDIC_ITERS)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	// predicted calibration state
	logic signed [15:0] axis_lo [3];
	logic signed [15:0] axis_hi [3];
	logic [15:0]        quiet_ticks;
	bit                 cal_running;
	bit                 cal_valid;
	logic signed [15:0] cal_offset [3];
	logic [15:0]        cal_span [2];
	logic [15:0]        timeout_ticks;

	compass_result_t pending_results [$];
	compass_result_t no_result;
	stim_row_t       stim_rows [NUM_ROWS];

	int errors;
	int live_reqs;
	int req_total;
	int cal_done_count;
	int heading_count;
	int flagged_count;
	bit gaps_on;

	// sample cloud of the current calibration run
	int cloud_center [3];
	int cloud_radius;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// gap length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [15:0] clip16(input int v);
		if (v > 32767)
			return SMP_MAX;
		if (v < -32768)
			return SMP_MIN;
		return 16'(v);
	endfunction

	function automatic logic signed [15:0] rand16();
		return 16'($urandom);
	endfunction

	function automatic logic signed [15:0] spread(input int center, input int radius);
		return clip16(center + int'($urandom_range(0, 2 * radius)) - radius);
	endfunction

	function automatic logic signed [15:0] pick_extreme();
		return ($urandom_range(0, 1) != 0) ? SMP_MAX : SMP_MIN;
	endfunction

	// vectoring cordic, angle of (xa, yb) in centidegrees
	function automatic int cordic_heading(input longint xa, input longint yb);
		longint x, y, z, t, nx, ny, r;
		if (xa == 0 && yb == 0)
			return 0;
		x = xa * 64'sd16777216;
		y = yb * 64'sd16777216;
		z = 0;
		// quarter-turn pre-rotation for a negative x term
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = 64'sd589824000;
			end else begin
				x = -y;
				y = t;
				z = -64'sd589824000;
			end
		end
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += ATAN_CDEG[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= ATAN_CDEG[i];
			end
			x = nx;
			y = ny;
		end
		r = (z + 32768) >>> 16;
		if (r > 18000)
			r = 18000;
		if (r < -18000)
			r = -18000;
		return int'(r);
	endfunction

	// advance the calibration state by one request and give its result
	function automatic void next_compass_result(input action_t act,
		input logic signed [15:0] xs, input logic signed [15:0] ys,
		input logic signed [15:0] zs, output compass_result_t res);
		logic signed [15:0] s [3];
		bit widened;
		int sum;
		longint dx, dy, spx, spy;
		res.status  = ST_ACCEPTED;
		res.heading = '0;
		s[0] = xs;
		s[1] = ys;
		s[2] = zs;
		req_total++;
		case (act)
			ACT_START: begin
				for (int k = 0; k < 3; k++) begin
					axis_lo[k] = SMP_MAX;
					axis_hi[k] = SMP_MIN;
				end
				quiet_ticks = '0;
				cal_running = 1'b1;
				live_reqs++;
			end
			ACT_SAMPLE: begin
				if (cal_running) begin
					live_reqs++;
					widened = 1'b0;
					for (int k = 0; k < 3; k++) begin
						if (s[k] < axis_lo[k]) begin
							axis_lo[k] = s[k];
							widened = 1'b1;
						end
						if (s[k] > axis_hi[k]) begin
							axis_hi[k] = s[k];
							widened = 1'b1;
						end
					end
					if (widened)
						quiet_ticks = '0;
				end
			end
			ACT_TICK: begin
				if (cal_running) begin
					live_reqs++;
					if (quiet_ticks != QUIET_TOP)
						quiet_ticks++;
					// timeout reached: latch midpoints and spans
					if (quiet_ticks >= timeout_ticks) begin
						for (int k = 0; k < 3; k++) begin
							sum = int'(axis_lo[k]) + int'(axis_hi[k]);
							cal_offset[k] = 16'(sum / 2);
						end
						for (int k = 0; k < 2; k++) begin
							sum = int'(axis_hi[k]) - int'(axis_lo[k]);
							cal_span[k] = (sum >= 0) ? 16'(sum) : 16'd0;
						end
						cal_running = 1'b0;
						cal_valid   = 1'b1;
						res.status  = ST_CAL_DONE;
						cal_done_count++;
					end
				end
			end
			ACT_HEADING: begin
				live_reqs++;
				if (!cal_valid) begin
					res.status = ST_NOT_CAL;
					flagged_count++;
				end else if (cal_span[0] == 0 || cal_span[1] == 0) begin
					res.status = ST_ZERO_SPAN;
					flagged_count++;
				end else begin
					dx  = xs;
					dy  = ys;
					dx  = dx - cal_offset[0];
					dy  = dy - cal_offset[1];
					spx = cal_span[0];
					spy = cal_span[1];
					res.heading = 16'(cordic_heading(dx * spy, -dy * spx));
					res.status  = ST_HEADING;
					heading_count++;
				end
			end
			default: ;
		endcase
		res.off_x = cal_offset[0];
		res.off_y = cal_offset[1];
		res.off_z = cal_offset[2];
		res.cal   = cal_valid;
	endfunction

	// one request through the handshake, expectation queued on acceptance
	task automatic send_request(input action_t act, input logic signed [15:0] xs,
		input logic signed [15:0] ys, input logic signed [15:0] zs,
		input bit use_typed, input compass_result_t typed_res);
		int gap;
		compass_result_t res;
		gap = pick_gap();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid    <= 1'b1;
		req_if.action   <= act;
		req_if.x_sample <= xs;
		req_if.y_sample <= ys;
		req_if.z_sample <= zs;
		do @(posedge clk); while (!req_if.ready);
		next_compass_result(act, xs, ys, zs, res);
		if (use_typed)
			pending_results.push_back(typed_res);
		else
			pending_results.push_back(res);
	endtask

	task automatic send_sample();
		send_request(ACT_SAMPLE, spread(cloud_center[0], cloud_radius),
			spread(cloud_center[1], cloud_radius), spread(cloud_center[2], cloud_radius),
			1'b0, no_result);
	endtask

	// heading near the offsets, anywhere, or at the corners
	task automatic send_heading();
		int mode;
		mode = $urandom_range(0, 99);
		if (mode < 50)
			send_request(ACT_HEADING, spread(cal_offset[0], 4000), spread(cal_offset[1], 4000),
				rand16(), 1'b0, no_result);
		else if (mode < 85)
			send_request(ACT_HEADING, rand16(), rand16(), rand16(), 1'b0, no_result);
		else
			send_request(ACT_HEADING, pick_extreme(), pick_extreme(), pick_extreme(),
				1'b0, no_result);
	endtask

	// hold requests until every expected result is back
	task automatic wait_for_results(input int settle);
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_quiet_timeout(input logic [15:0] v);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= v;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid  <= 1'b0;
		timeout_ticks = v;
	endtask

	// one calibration run with headings, or a few noise requests
	task automatic run_episode();
		int n;
		int guard;
		int r;
		gaps_on = ($urandom_range(0, 5) != 0);
		if ($urandom_range(0, 19) == 0)
			wait_for_results(0);
		if ($urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 4);
			repeat (n)
				send_request(action_t'($urandom_range(0, 3)), rand16(), rand16(), rand16(),
					1'b0, no_result);
			return;
		end
		for (int k = 0; k < 3; k++)
			cloud_center[k] = int'($urandom_range(0, 65535)) - 32768;
		r = $urandom_range(0, 2);
		if (r == 0)
			cloud_radius = $urandom_range(0, 64);
		else if (r == 1)
			cloud_radius = $urandom_range(65, 4000);
		else
			cloud_radius = 65535;
		send_request(ACT_START, rand16(), rand16(), rand16(), 1'b0, no_result);
		r = $urandom_range(0, 19);
		n = (r == 0) ? 0 : (r == 1) ? 1 : $urandom_range(2, 10);
		repeat (n) send_sample();
		// restart in the middle of a run
		if ($urandom_range(0, 7) == 0) begin
			send_request(ACT_START, rand16(), rand16(), rand16(), 1'b0, no_result);
			n = $urandom_range(1, 4);
			repeat (n) send_sample();
		end
		guard = 0;
		while (cal_running && guard < 200) begin
			if ($urandom_range(0, 5) == 0)
				send_sample();
			else
				send_request(ACT_TICK, rand16(), rand16(), rand16(), 1'b0, no_result);
			guard++;
		end
		n = $urandom_range(1, 6);
		repeat (n) send_heading();
	endtask

	// result side: random stalls, compare with the oldest expectation
	task automatic compare_field(input string name, input logic signed [31:0] want,
		input logic signed [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	initial begin
		int stall;
		compass_result_t want;
		stall = 0;
		rsp_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_if.valid && rsp_if.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result with no request waiting, status %0d", $time,
						rsp_if.status);
					errors++;
				end else begin
					want = pending_results.pop_front();
					compare_field("status", want.status, rsp_if.status);
					compare_field("heading", want.heading, rsp_if.heading_centideg);
					compare_field("offset_x", want.off_x, rsp_if.offset_x);
					compare_field("offset_y", want.off_y, rsp_if.offset_y);
					compare_field("offset_z", want.off_z, rsp_if.offset_z);
					compare_field("is_calibrated", want.cal, rsp_if.is_calibrated);
				end
				stall = pick_gap();
			end else if (stall > 0) begin
				stall--;
			end
			rsp_if.ready <= (stall == 0);
		end
	end

	// main sequence
	initial begin
		int base;
		logic [15:0] tv;
		arst_n = 1'b0;
		req_if.valid    <= 1'b0;
		req_if.action   <= ACT_START;
		req_if.x_sample <= '0;
		req_if.y_sample <= '0;
		req_if.z_sample <= '0;
		cfg_if.valid    <= 1'b0;
		cfg_if.data     <= '0;
		errors = 0;
		gaps_on = 1'b1;
		for (int k = 0; k < 3; k++) begin
			axis_lo[k] = SMP_MAX;
			axis_hi[k] = SMP_MIN;
			cal_offset[k] = '0;
		end
		cal_span[0]   = '0;
		cal_span[1]   = '0;
		quiet_ticks   = '0;
		cal_running   = 1'b0;
		cal_valid     = 1'b0;
		timeout_ticks = TIMEOUT_RST;
		no_result = '{ST_ACCEPTED, 0, 0, 0, 0, 1'b0};

		// directed rows; typed results where they are obvious
		stim_rows = '{
			// heading before calibration
			'{ACT_HEADING, 0, 0, 0, 1, 1'b1, '{ST_NOT_CAL, 0, 0, 0, 0, 1'b0}},
			'{ACT_HEADING, SMP_MAX, SMP_MIN, SMP_MIN, 1, 1'b1,
				'{ST_NOT_CAL, 0, 0, 0, 0, 1'b0}},
			// sample and tick while idle are ignored
			'{ACT_SAMPLE, SMP_MAX, SMP_MIN, -1, 1, 1'b1, '{ST_ACCEPTED, 0, 0, 0, 0, 1'b0}},
			'{ACT_TICK, SMP_MIN, SMP_MAX, SMP_MAX, 1, 1'b1,
				'{ST_ACCEPTED, 0, 0, 0, 0, 1'b0}},
			// calibration with no samples under the reset timeout
			'{ACT_START, 0, 0, 0, 1, 1'b1, '{ST_ACCEPTED, 0, 0, 0, 0, 1'b0}},
			'{ACT_TICK, 0, 0, 0, 999, 1'b1, '{ST_ACCEPTED, 0, 0, 0, 0, 1'b0}},
			'{ACT_TICK, 0, 0, 0, 1, 1'b1, '{ST_CAL_DONE, 0, 0, 0, 0, 1'b1}},
			// heading with zero spans
			'{ACT_HEADING, 1000, -1000, 7, 1, 1'b1, '{ST_ZERO_SPAN, 0, 0, 0, 0, 1'b1}},
			// restart while calibrating under a timeout of 3, then full-scale extremes
			'{ACT_START, 0, 0, 0, 1, 1'b1, '{ST_ACCEPTED, 0, 0, 0, 0, 1'b1}},
			'{ACT_SAMPLE, 500, 600, 700, 1, 1'b0, '{ST_ACCEPTED, 0, 0, 0, 0, 1'b0}},
			'{ACT_START, 0, 0, 0, 1, 1'b1, '{ST_ACCEPTED, 0, 0, 0, 0, 1'b1}},
			'{ACT_SAMPLE, SMP_MAX, SMP_MAX, SMP_MAX, 1, 1'b0,
				'{ST_ACCEPTED, 0, 0, 0, 0, 1'b0}},
			'{ACT_SAMPLE, SMP_MIN, SMP_MIN, SMP_MIN, 1, 1'b0,
				'{ST_ACCEPTED, 0, 0, 0, 0, 1'b0}},
			'{ACT_SAMPLE, 0, 0, 0, 1, 1'b0, '{ST_ACCEPTED, 0, 0, 0, 0, 1'b0}},
			'{ACT_TICK, 0, 0, 0, 2, 1'b0, '{ST_ACCEPTED, 0, 0, 0, 0, 1'b0}},
			'{ACT_TICK, 0, 0, 0, 1, 1'b1, '{ST_CAL_DONE, 0, 0, 0, 0, 1'b1}},
			// zero vector and the negative x axis, then further headings and a new start
			'{ACT_HEADING, 0, 0, 0, 1, 1'b1, '{ST_HEADING, 0, 0, 0, 0, 1'b1}},
			'{ACT_HEADING, SMP_MIN, 0, 0, 1, 1'b1, '{ST_HEADING, 18000, 0, 0, 0, 1'b1}},
			'{ACT_HEADING, SMP_MAX, SMP_MIN, SMP_MIN, 1, 1'b0,
				'{ST_ACCEPTED, 0, 0, 0, 0, 1'b0}},
			'{ACT_HEADING, 1000, 1000, 0, 1, 1'b0, '{ST_ACCEPTED, 0, 0, 0, 0, 1'b0}},
			'{ACT_HEADING, 0, SMP_MAX, 0, 1, 1'b0, '{ST_ACCEPTED, 0, 0, 0, 0, 1'b0}},
			'{ACT_HEADING, SMP_MIN, SMP_MIN, 0, 1, 1'b0, '{ST_ACCEPTED, 0, 0, 0, 0, 1'b0}},
			'{ACT_HEADING, -5, 3, SMP_MAX, 1, 1'b0, '{ST_ACCEPTED, 0, 0, 0, 0, 1'b0}},
			'{ACT_START, 0, 0, 0, 1, 1'b0, '{ST_ACCEPTED, 0, 0, 0, 0, 1'b0}},
			'{ACT_SAMPLE, 100, -50, 20, 1, 1'b0, '{ST_ACCEPTED, 0, 0, 0, 0, 1'b0}}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			// short quiet timeout from the second directed calibration on
			if (i == SHORT_TIMEOUT_ROW) begin
				wait_for_results(0);
				write_quiet_timeout(16'd3);
			end
			for (int r = 0; r < stim_rows[i].reps; r++)
				send_request(stim_rows[i].act, stim_rows[i].x, stim_rows[i].y, stim_rows[i].z,
					stim_rows[i].typed, stim_rows[i].res);
		end

		// random calibration runs under several timeouts
		base = live_reqs;
		for (int p = 0; p < PHASES; p++) begin
			wait_for_results(40);
			if (p == 0)
				tv = 16'd1;
			else if (p == 1)
				tv = 16'd0;
			else
				tv = $urandom_range(2, 12);
			write_quiet_timeout(tv);
			while (live_reqs - base < (p + 1) * RANDOM_REQS / PHASES)
				run_episode();
		end

		wait_for_results(40);
		$display("covered %0d requests: %0d calibrations finished, %0d headings computed,",
			req_total, cal_done_count, heading_count);
		$display("%0d headings flagged as uncalibrated or zero span", flagged_count);
		if (errors == 0)
			$display("compass_calibration_heading regression: pass");
		else
			$display("compass_calibration_heading regression: fail");
		$finish;
	end

	// run limit
	initial begin
		#4000000;
		$display("compass_calibration_heading regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
sv/cch_pkg.sv
sv/cch_intf.sv
sv/compass_calibration_heading.sv
tb/sv/tb.sv
